// ----- src/itoa_pkg.sv -----
// Shared types and constants for the signed integer to decimal text converter.
// No dependencies; every other file in src imports this package.

package itoa_pkg;

    // ASCII codes produced by the block.
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // Bits per BCD digit and magnitude bits consumed per conversion step.
    localparam int DIGIT_BITS = 4;
    localparam int STEP_BITS  = 4;

    // Entries in the queue between the front end and the converter (power of two).
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_RUN,
        CONV_DONE
    } t_conv_state;

    // Status from the converter to the emitter.
    typedef struct packed {
        logic done;
        logic neg;
    } t_conv_ctrl;

endpackage

// ----- src/itoa_front.sv -----
// Front end: accepts input transfers and splits each value into sign and magnitude.
// Depends on itoa_pkg; feeds itoa_queue.

module itoa_front
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_full,
    output logic                  o_push,
    output logic                  o_neg,
    output logic [VALUE_BITS-1:0] o_mag
);

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign o_neg   = i_value[VALUE_BITS-1];

    // The most negative value wraps to 2^(VALUE_BITS-1), which is its true
    // magnitude when read as unsigned.
    assign o_mag = o_neg ? (~i_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : i_value;

endmodule

// ----- src/itoa_queue.sv -----
// Short register queue holding sign and magnitude between front end and converter.
// Depends on itoa_pkg for its depth.

module itoa_queue
    import itoa_pkg::*;
#(
    parameter int WIDTH = 33
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [QIW-1:0]   r_wp, n_wp;
    logic [QIW-1:0]   r_rp, n_rp;
    logic [QCW-1:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == QCW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = r_wp + QIW'(1);
        end
        if (i_pop) begin
            n_rp = r_rp + QIW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QCW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// ----- src/itoa_conv.sv -----
// Binary to BCD converter: shift-and-add-3, four magnitude bits per cycle.
// Depends on itoa_pkg; reads itoa_queue and hands digits to itoa_emit.

module itoa_conv
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  logic                  i_q_neg,
    input  logic [VALUE_BITS-1:0] i_q_mag,
    output logic                  o_pop,
    output t_conv_ctrl            o_ctrl,
    output logic [((((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS * 1233) / 4096 + 1)
                  * DIGIT_BITS - 1:0] o_bcd,
    input  logic                  i_take
);

    localparam int STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PADW  = STEPS * STEP_BITS;
    localparam int NDIG  = (PADW * 1233) / 4096 + 1;
    localparam int BCDW  = NDIG * DIGIT_BITS;
    localparam int SCW   = $clog2(STEPS);

    t_conv_state      r_state, n_state;
    logic [BCDW-1:0]  r_bcd, n_bcd;
    logic [PADW-1:0]  r_bin, n_bin;
    logic [SCW-1:0]   r_step, n_step;
    logic             r_neg, n_neg;

    // Double dabble over STEP_BITS magnitude bits: STEP_BITS shifts, each preceded by the
    // add-3 correction on every digit of five or more.
    function automatic logic [BCDW-1:0] dabble(input logic [BCDW-1:0] bcd,
                                               input logic [STEP_BITS-1:0] bits);
        logic [BCDW-1:0] acc;
        acc = bcd;
        for (int j = STEP_BITS - 1; j >= 0; j--) begin
            for (int k = 0; k < NDIG; k++) begin
                if (acc[k*DIGIT_BITS +: DIGIT_BITS] >= DIGIT_BITS'(5)) begin
                    acc[k*DIGIT_BITS +: DIGIT_BITS] =
                        acc[k*DIGIT_BITS +: DIGIT_BITS] + DIGIT_BITS'(3);
                end
            end
            acc = {acc[BCDW-2:0], bits[j]};
        end
        return acc;
    endfunction

    always_comb begin
        n_state = r_state;
        n_bcd   = r_bcd;
        n_bin   = r_bin;
        n_step  = r_step;
        n_neg   = r_neg;
        o_pop   = 1'b0;
        case (r_state)
            CONV_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_bin   = PADW'(i_q_mag);
                    n_bcd   = '0;
                    n_neg   = i_q_neg;
                    n_step  = SCW'(STEPS - 1);
                    n_state = CONV_RUN;
                end
            end
            CONV_RUN: begin
                n_bcd = dabble(r_bcd, r_bin[PADW-1 -: STEP_BITS]);
                n_bin = {r_bin[PADW-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
                if (r_step == '0) begin
                    n_state = CONV_DONE;
                end else begin
                    n_step = r_step - SCW'(1);
                end
            end
            CONV_DONE: begin
                if (i_take) begin
                    n_state = CONV_IDLE;
                end
            end
            default: begin
                n_state = CONV_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CONV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd  <= n_bcd;
        r_bin  <= n_bin;
        r_step <= n_step;
        r_neg  <= n_neg;
    end

    assign o_ctrl.done = (r_state == CONV_DONE);
    assign o_ctrl.neg  = r_neg;
    assign o_bcd       = r_bcd;

endmodule

// ----- src/itoa_emit.sv -----
// Character emitter: takes finished BCD digits, skips leading zeros and sends
// the sign and digits out one transfer at a time through an output register.
// Depends on itoa_pkg; fed by itoa_conv.

module itoa_emit
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_conv_ctrl i_ctrl,
    input  logic [((((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS * 1233) / 4096 + 1)
                  * DIGIT_BITS - 1:0] i_bcd,
    output logic       o_take,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_char_code,
    output logic       o_last_char
);

    localparam int STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int NDIG  = (STEPS * STEP_BITS * 1233) / 4096 + 1;
    localparam int IW    = $clog2(NDIG);

    logic [NDIG-1:0][DIGIT_BITS-1:0] r_bcd;
    logic [NDIG-1:0][DIGIT_BITS-1:0] w_digits;
    logic [IW-1:0]                   r_idx;
    logic [IW-1:0]                   w_msd;
    logic                            r_busy;
    logic                            r_neg;
    logic                            r_out_valid;
    logic [7:0]                      r_char;
    logic                            r_last;
    logic                            w_emit;
    logic [DIGIT_BITS-1:0]           w_digit;

    assign w_digits = i_bcd;

    // Highest nonzero digit; zero itself leaves the index at the units digit.
    always_comb begin
        w_msd = '0;
        for (int k = 0; k < NDIG; k++) begin
            if (w_digits[k] != '0) begin
                w_msd = IW'(k);
            end
        end
    end

    assign o_take  = i_ctrl.done && !r_busy;
    assign w_emit  = r_busy && (!r_out_valid || i_ready);
    assign w_digit = r_bcd[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_busy <= 1'b1;
            end else if (w_emit && !r_neg && r_idx == '0) begin
                r_busy <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_bcd <= w_digits;
            r_idx <= w_msd;
            r_neg <= i_ctrl.neg;
        end else if (w_emit) begin
            if (r_neg) begin
                r_neg <= 1'b0;
            end else if (r_idx != '0) begin
                r_idx <= r_idx - IW'(1);
            end
        end
        if (w_emit) begin
            if (r_neg) begin
                r_char <= CHAR_MINUS;
                r_last <= 1'b0;
            end else begin
                r_char <= CHAR_ZERO + 8'(w_digit);
                r_last <= (r_idx == '0);
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

endmodule

// ----- src/signed_int_to_decimal_ascii.sv -----
// Top level of the signed integer to decimal ASCII text converter.
// Depends on itoa_pkg, itoa_front, itoa_queue, itoa_conv and itoa_emit.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_ready    i_value
//   output   out        o_valid / i_ready    o_char_code, o_last_char
//
// Each item is popped from the queue, converted in the shift-and-add-3 unit and then handed
// over to the emitter. The emitter sends one character per cycle while the receiver is ready.
// Conversion of the next item overlaps emission of the current one. Reset clears only control
// state. Either side may stall freely; the two-entry queue and the output register absorb
// the stall.

module signed_int_to_decimal_ascii
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_char_code,
    output logic                  o_last_char
);

    localparam int STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int NDIG  = (STEPS * STEP_BITS * 1233) / 4096 + 1;
    localparam int BCDW  = NDIG * DIGIT_BITS;

    logic                  w_full;
    logic                  w_push;
    logic                  w_neg;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_pop;
    logic                  w_empty;
    logic [VALUE_BITS:0]   w_qdata;
    t_conv_ctrl            w_ctrl;
    logic [BCDW-1:0]       w_bcd;
    logic                  w_take;

    itoa_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (i_value),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_neg   (w_neg),
        .o_mag   (w_mag)
    );

    itoa_queue #(
        .WIDTH(VALUE_BITS + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata ({w_neg, w_mag}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rdata (w_qdata),
        .o_empty (w_empty)
    );

    itoa_conv #(
        .VALUE_BITS(VALUE_BITS)
    ) u_conv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_q_neg   (w_qdata[VALUE_BITS]),
        .i_q_mag   (w_qdata[VALUE_BITS-1:0]),
        .o_pop     (w_pop),
        .o_ctrl    (w_ctrl),
        .o_bcd     (w_bcd),
        .i_take    (w_take)
    );

    itoa_emit #(
        .VALUE_BITS(VALUE_BITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_bcd       (w_bcd),
        .o_take      (w_take),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

    // Every character is either the minus sign or a decimal digit.
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == CHAR_MINUS ||
                     (o_char_code >= CHAR_ZERO && o_char_code <= CHAR_ZERO + 8'd9)))
        else $error("character outside the sign and digit set");

    // A run never ends on the sign.
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char_code == CHAR_MINUS) |-> !o_last_char)
        else $error("run ends on the minus sign");

    // Inside a run the next character is ready right after each transfer.
    a_run_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_char) |=> o_valid)
        else $error("gap inside a character run");

    // The sign is always followed by a digit.
    a_digit_after_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_char_code == CHAR_MINUS) |=> (o_char_code != CHAR_MINUS))
        else $error("sign not followed by a digit");

endmodule

// ----- bench/tb_signed_int_to_decimal_ascii.sv -----
// Self-checking testbench for signed_int_to_decimal_ascii: directed table, then random values.
// Expected runs: typed row text or a local decimal formatter; depends on itoa_pkg and the RTL.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;
    import itoa_pkg::*;

    localparam int VALUE_BITS  = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_ITEMS = 208;
    localparam int DIRECTED_ROWS = 22;
    localparam int HOLD_LENGTH = 300;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_text_char;

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        string                 text;   // Empty means the formatter supplies the text.
    } t_directed_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [VALUE_BITS-1:0] i_value;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [7:0]            o_char_code;
    logic                  o_last_char;

    t_text_char    pending_text[$];
    t_directed_row directed_rows[DIRECTED_ROWS];
    int            error_count = 0;
    int            cycle_count = 0;
    int            hold_cycles = 0;
    bit            hold_taken = 1'b0;
    bit            hold_request;
    bit            steady;

    signed_int_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_char_code(o_char_code),
        .o_last_char(o_last_char)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                 want);
        error_count++;
    endtask

    // Queues the decimal text of one value, sign first, most significant digit first.
    function automatic void format_decimal(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] magnitude;
        logic [7:0]            digits[$];
        t_text_char            entry;
        magnitude = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
        do begin
            digits.push_front(CHAR_ZERO + 8'(magnitude % 10));
            magnitude = magnitude / 10;
        end while (magnitude != 0);
        if (value[VALUE_BITS-1]) begin
            entry.char_code = CHAR_MINUS;
            entry.last_char = 1'b0;
            pending_text.push_back(entry);
        end
        foreach (digits[i]) begin
            entry.char_code = digits[i];
            entry.last_char = (i == digits.size() - 1);
            pending_text.push_back(entry);
        end
    endfunction

    function automatic void queue_literal(input string text);
        t_text_char entry;
        for (int i = 0; i < text.len(); i++) begin
            entry.char_code = text[i];
            entry.last_char = (i == text.len() - 1);
            pending_text.push_back(entry);
        end
    endfunction

    // Mixes full-width words, tiny magnitudes and every text length in between.
    function automatic logic [VALUE_BITS-1:0] pick_value();
        logic [VALUE_BITS-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom();
            1: v = $urandom_range(0, 20);
            default: v = $urandom() >> $urandom_range(0, VALUE_BITS - 1);
        endcase
        if ($urandom_range(0, 1) == 1) begin
            v = ~v + 1'b1;
        end
        return v;
    endfunction

    // Offers one value and waits for its transfer; text is empty unless typed in.
    task automatic send_value(input logic [VALUE_BITS-1:0] value, input string text);
        int gap;
        gap = (!steady && $urandom_range(0, 99) < 16) ? $urandom_range(1, 3) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            i_value <= $urandom();
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        if (text.len() != 0) begin
            queue_literal(text);
        end else begin
            format_decimal(value);
        end
    endtask

    task automatic drain_text();
        i_valid <= 1'b0;
        while (pending_text.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_char();
        t_text_char want;
        if (pending_text.size() == 0) begin
            report_mismatch("characters pending at transfer", 0, 1);
        end else begin
            want = pending_text.pop_front();
            if (o_char_code !== want.char_code) begin
                report_mismatch("char_code", o_char_code, want.char_code);
            end
            if (o_last_char !== want.last_char) begin
                report_mismatch("last_char", o_last_char, want.last_char);
            end
        end
    endtask

    // Receiver: checks each transfer, then picks ready for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            check_char();
        end
        if (hold_request && !hold_taken) begin
            hold_taken  = 1'b1;
            hold_cycles = HOLD_LENGTH;
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_ready <= 1'b0;
        end else if (steady) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= 16);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d characters pending", cycle_count,
                     pending_text.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        hold_request = 1'b0;
        steady       = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_value      = '0;

        directed_rows = '{
            '{32'd0,           "0"},
            '{32'd1,           "1"},
            '{-32'sd1,         "-1"},
            '{32'd9,           "9"},
            '{32'd10,          "10"},
            '{-32'sd10,        "-10"},
            '{32'h7FFF_FFFF,   "2147483647"},
            '{32'h8000_0000,   "-2147483648"},
            '{32'h8000_0001,   "-2147483647"},
            '{32'd1000000000,  "1000000000"},
            '{-32'sd999999999, "-999999999"},
            '{32'd99,          ""},
            '{32'd100,         ""},
            '{32'd4095,        ""},
            '{32'd65536,       ""},
            '{-32'sd65536,     ""},
            '{32'h5555_5555,   ""},
            '{32'hAAAA_AAAA,   ""},
            '{32'd12345,       ""},
            '{-32'sd7,         ""},
            '{32'd1999999999,  ""},
            '{32'hFFFF_FFF6,   ""}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_value(directed_rows[i].value, directed_rows[i].text);
        end
        // The sender rests until every character of the table has come out.
        drain_text();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 60) begin
                // Long receiver stall while values keep coming, so the input backs up.
                hold_request = 1'b1;
            end
            if (n == 100) begin
                steady = 1'b1;
            end
            if (n == 160) begin
                steady = 1'b0;
            end
            send_value(pick_value(), "");
        end

        drain_text();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/itoa_pkg.sv
src/itoa_front.sv
src/itoa_queue.sv
src/itoa_conv.sv
src/itoa_emit.sv
src/signed_int_to_decimal_ascii.sv
bench/tb_signed_int_to_decimal_ascii.sv
